// ----- hdl/tlvvm_pkg.sv -----
// Shared definitions for the two-level voxel visibility map.
// Field widths, register codes, defaults and controller/datapath interface structs.
// No dependencies.
`default_nettype none

package tlvvm_pkg;

   // Default store geometry
   localparam int MAX_X_DEF  = 128;
   localparam int MAX_Z_DEF  = 128;
   localparam int HEIGHT_DEF = 32;

   // Item field widths
   localparam int X_W   = 7;
   localparam int Y_W   = 5;
   localparam int Z_W   = 7;
   localparam int LVL_W = 2;
   localparam int CFG_W = 8;
   localparam int BUS_W = 32;
   localparam int PADDR_W = 3;

   // Item opcodes
   localparam logic OP_MARK  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register index codes, taken from paddr[2]
   localparam logic REG_WIDTH = 1'b0;
   localparam logic REG_DEPTH = 1'b1;

   localparam logic [CFG_W-1:0] EXTENT_RESET = 8'd128;

   typedef struct packed {
      logic load;        // capture the accepted item
      logic clear;       // write one zero byte of the clearing pass
      logic rd;          // issue a store read
      logic wr;          // write back a raised byte
      logic answer;      // produce the query answer
      logic sel_coarse;  // address the coarse entry
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic lvl_hi;      // query goes to the coarse map
      logic clear_last;
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/two_level_voxel_visibility_map.sv -----
// Top level of the two-level voxel visibility map.
// Depends on tlvvm_pkg, tlvvm_ram, tlvvm_csr, tlvvm_datapath and tlvvm_ctrl.
//
// Items are taken when start is high and busy is low; the block then works on
// that one item alone and takes no new item until busy is low again. A mark
// goes through entry address arithmetic (multipliers, then scaling by the
// column height, then the coarse base add), then a read and a write-back of
// the fine byte and of the coarse byte through the level store (one read port,
// one write port); a query goes through the same arithmetic, then a read and
// an answer step. A query answer appears on rsp_visible with rsp_strobe high
// for exactly one cycle, the first cycle in which busy is low again; the
// receiver cannot stall it, so it must take every beat. After reset the store
// is zeroed one byte per cycle, all STORE_BYTES bytes (18432 at the default
// sizes), while busy stays high; configuration writes are taken meanwhile.
`default_nettype none

module two_level_voxel_visibility_map #(
   parameter int MAX_X  = tlvvm_pkg::MAX_X_DEF,
   parameter int MAX_Z  = tlvvm_pkg::MAX_Z_DEF,
   parameter int HEIGHT = tlvvm_pkg::HEIGHT_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire                              req_op,
   input  wire  [tlvvm_pkg::X_W-1:0]        req_pos_x,
   input  wire  [tlvvm_pkg::Y_W-1:0]        req_pos_y,
   input  wire  [tlvvm_pkg::Z_W-1:0]        req_pos_z,
   input  wire  [tlvvm_pkg::LVL_W-1:0]      req_vis_level,
   output logic                             rsp_strobe,
   output logic                             rsp_visible,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [tlvvm_pkg::PADDR_W-1:0]    paddr,
   input  wire  [tlvvm_pkg::BUS_W-1:0]      pwdata,
   output logic [tlvvm_pkg::BUS_W-1:0]      prdata,
   output logic                             pready
);

   localparam int FINE_BYTES   = ((MAX_X / 2) * (MAX_Z / 2) * (HEIGHT / 2)) / 4;
   localparam int COARSE_BYTES = ((MAX_X / 4) * (MAX_Z / 4) * (HEIGHT / 4)) / 4;
   localparam int STORE_BYTES  = FINE_BYTES + COARSE_BYTES;
   localparam int ADDR_W       = $clog2(STORE_BYTES);

   tlvvm_pkg::cmd_type          cmd;
   tlvvm_pkg::status_type       status;
   logic [tlvvm_pkg::CFG_W-1:0] width_in_use;
   logic [tlvvm_pkg::CFG_W-1:0] depth_in_use;
   logic                        ram_wr_en;
   logic [ADDR_W-1:0]           ram_wr_addr;
   logic [7:0]                  ram_wr_data;
   logic                        ram_rd_en;
   logic [ADDR_W-1:0]           ram_rd_addr;
   logic [7:0]                  ram_rd_data;

   tlvvm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .width_in_use (width_in_use),
      .depth_in_use (depth_in_use)
   );

   tlvvm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   tlvvm_datapath #(
      .HEIGHT      (HEIGHT),
      .STORE_BYTES (STORE_BYTES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_op),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_vis_level (req_vis_level),
      .width_in_use  (width_in_use),
      .depth_in_use  (depth_in_use),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_visible   (rsp_visible)
   );

   tlvvm_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_level_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

// ----- hdl/tlvvm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tlvvm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hdl/tlvvm_csr.sv -----
// Configuration registers (grid width and depth in use) behind the APB-style port.
// Depends on tlvvm_pkg.
`default_nettype none

module tlvvm_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire  [tlvvm_pkg::PADDR_W-1:0]    paddr,
   input  wire  [tlvvm_pkg::BUS_W-1:0]      pwdata,
   output logic [tlvvm_pkg::BUS_W-1:0]      prdata,
   output logic                             pready,
   output logic [tlvvm_pkg::CFG_W-1:0]      width_in_use,
   output logic [tlvvm_pkg::CFG_W-1:0]      depth_in_use
);

   logic [tlvvm_pkg::CFG_W-1:0] width_ff, width_in;
   logic [tlvvm_pkg::CFG_W-1:0] depth_ff, depth_in;
   logic                        wr_beat;

   assign pready  = 1'b1;
   assign wr_beat = psel & penable & pwrite & pready;

   always_comb begin
      width_in = width_ff;
      depth_in = depth_ff;
      if (wr_beat) begin
         case (paddr[2])
            tlvvm_pkg::REG_WIDTH: width_in = pwdata[tlvvm_pkg::CFG_W-1:0];
            tlvvm_pkg::REG_DEPTH: depth_in = pwdata[tlvvm_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= tlvvm_pkg::EXTENT_RESET;
         depth_ff <= tlvvm_pkg::EXTENT_RESET;
      end else begin
         width_ff <= width_in;
         depth_ff <= depth_in;
      end
   end

   always_comb begin
      case (paddr[2])
         tlvvm_pkg::REG_WIDTH: prdata = tlvvm_pkg::BUS_W'(width_ff);
         tlvvm_pkg::REG_DEPTH: prdata = tlvvm_pkg::BUS_W'(depth_ff);
         default:              prdata = '0;
      endcase
   end

   assign width_in_use = width_ff;
   assign depth_in_use = depth_ff;

endmodule

`default_nettype wire

// ----- hdl/tlvvm_datapath.sv -----
// Datapath: item registers, three-stage entry address calculation, byte merge,
// clearing counter and query answer. Drives the level store RAM ports.
// Depends on tlvvm_pkg.
`default_nettype none

module tlvvm_datapath #(
   parameter int HEIGHT      = tlvvm_pkg::HEIGHT_DEF,
   parameter int STORE_BYTES = 18432
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire tlvvm_pkg::cmd_type          cmd,
   output tlvvm_pkg::status_type            status,
   input  wire                              req_op,
   input  wire  [tlvvm_pkg::X_W-1:0]        req_pos_x,
   input  wire  [tlvvm_pkg::Y_W-1:0]        req_pos_y,
   input  wire  [tlvvm_pkg::Z_W-1:0]        req_pos_z,
   input  wire  [tlvvm_pkg::LVL_W-1:0]      req_vis_level,
   input  wire  [tlvvm_pkg::CFG_W-1:0]      width_in_use,
   input  wire  [tlvvm_pkg::CFG_W-1:0]      depth_in_use,
   output logic                             ram_wr_en,
   output logic [$clog2(STORE_BYTES)-1:0]   ram_wr_addr,
   output logic [7:0]                       ram_wr_data,
   output logic                             ram_rd_en,
   output logic [$clog2(STORE_BYTES)-1:0]   ram_rd_addr,
   input  wire  [7:0]                       ram_rd_data,
   output logic                             rsp_strobe,
   output logic                             rsp_visible
);

   localparam int ADDR_W    = $clog2(STORE_BYTES);
   // Largest entry number reachable from any field and register value
   localparam int ENTRY_MAX = (127 * 127 * HEIGHT) / 2 + (31 * 63 + 31) * (HEIGHT / 4) + 7;
   localparam int ENTRY_W   = $clog2(ENTRY_MAX + 1);
   localparam int CB_W      = ENTRY_W + 1;
   localparam int FP_W      = 14;
   localparam int CP_W      = 11;
   localparam int BP_W      = 14;

   // Item registers
   logic                        op_ff, op_in;
   logic [tlvvm_pkg::X_W-1:0]   x_ff, x_in;
   logic [tlvvm_pkg::Y_W-1:0]   y_ff, y_in;
   logic [tlvvm_pkg::Z_W-1:0]   z_ff, z_in;
   logic [tlvvm_pkg::LVL_W-1:0] lvl_ff, lvl_in;

   // Address stages
   logic [FP_W-1:0]    fprod_ff, fprod_in;
   logic [CP_W-1:0]    cprod_ff, cprod_in;
   logic [BP_W-1:0]    bprod_ff, bprod_in;
   logic [ENTRY_W-1:0] fine_ff, fine_in;
   logic [ENTRY_W-1:0] cbase_ff, cbase_in;
   logic [ENTRY_W-1:0] cofs_ff, cofs_in;
   logic [ENTRY_W-1:0] coarse_ff, coarse_in;

   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic               strobe_ff, strobe_in;
   logic               visible_ff, visible_in;

   logic [ENTRY_W-1:0]         sel_entry;
   logic [31:0]                byte_idx;
   logic                       in_range;
   logic [2:0]                 shamt;
   logic [tlvvm_pkg::LVL_W-1:0] field;
   logic [tlvvm_pkg::LVL_W-1:0] stored;
   logic [7:0]                 merged;
   logic                       raise;

   always_comb begin
      op_in  = op_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      lvl_in = lvl_ff;
      if (cmd.load) begin
         op_in  = req_op;
         x_in   = req_pos_x;
         y_in   = req_pos_y;
         z_in   = req_pos_z;
         lvl_in = req_vis_level;
      end
   end

   // Stage 1: products of coordinates and sizes
   assign fprod_in = FP_W'(z_ff[6:1]) * FP_W'(width_in_use[7:1]);
   assign cprod_in = CP_W'(z_ff[6:2]) * CP_W'(width_in_use[7:2]);
   assign bprod_in = BP_W'(width_in_use[7:1]) * BP_W'(depth_in_use[7:1]);

   // Stage 2: scale by the cell column heights
   assign fine_in  = ENTRY_W'(fprod_ff + FP_W'(x_ff[6:1])) * ENTRY_W'(HEIGHT / 2)
                     + ENTRY_W'(y_ff[4:1]);
   assign cbase_in = ENTRY_W'((CB_W'(bprod_ff) * CB_W'(HEIGHT)) >> 1);
   assign cofs_in  = ENTRY_W'(cprod_ff + CP_W'(x_ff[6:2])) * ENTRY_W'(HEIGHT / 4)
                     + ENTRY_W'(y_ff[4:2]);

   // Stage 3: coarse map sits after the fine map
   assign coarse_in = cbase_ff + cofs_ff;

   assign sel_entry = cmd.sel_coarse ? coarse_ff : fine_ff;
   assign byte_idx  = 32'(sel_entry[ENTRY_W-1:2]);
   assign in_range  = byte_idx < 32'(STORE_BYTES);
   assign shamt     = {sel_entry[1:0], 1'b0};
   assign field     = tlvvm_pkg::LVL_W'(ram_rd_data >> shamt);
   assign stored    = in_range ? field : '0;
   assign raise     = lvl_ff > field;
   assign merged    = (ram_rd_data & ~(8'h03 << shamt)) | (8'(lvl_ff) << shamt);

   assign clr_in     = cmd.clear ? clr_ff + ADDR_W'(1) : clr_ff;
   assign strobe_in  = cmd.answer;
   assign visible_in = cmd.answer ? (stored >= lvl_ff) : visible_ff;

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      lvl_ff     <= lvl_in;
      fprod_ff   <= fprod_in;
      cprod_ff   <= cprod_in;
      bprod_ff   <= bprod_in;
      fine_ff    <= fine_in;
      cbase_ff   <= cbase_in;
      cofs_ff    <= cofs_in;
      coarse_ff  <= coarse_in;
      visible_ff <= visible_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         clr_ff    <= clr_in;
         strobe_ff <= strobe_in;
      end
   end

   // Clearing pass owns the write port until it ends
   assign ram_wr_en   = cmd.clear | (cmd.wr & in_range & raise);
   assign ram_wr_addr = cmd.clear ? clr_ff : byte_idx[ADDR_W-1:0];
   assign ram_wr_data = cmd.clear ? 8'h00 : merged;
   assign ram_rd_en   = cmd.rd;
   assign ram_rd_addr = byte_idx[ADDR_W-1:0];

   assign status.is_query   = (op_ff == tlvvm_pkg::OP_QUERY);
   assign status.lvl_hi     = lvl_ff[1];
   assign status.clear_last = (clr_ff == ADDR_W'(STORE_BYTES - 1));

   assign rsp_strobe  = strobe_ff;
   assign rsp_visible = visible_ff;

endmodule

`default_nettype wire

// ----- hdl/tlvvm_ctrl.sv -----
// Controller state machine: clearing pass, address calculation wait, store
// read-modify-write sequence for marks and the read for queries.
// Depends on tlvvm_pkg.
`default_nettype none

module tlvvm_ctrl (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire tlvvm_pkg::status_type   status,
   output tlvvm_pkg::cmd_type           cmd
);

   typedef enum logic [10:0] {
      ST_CLEAR = 11'b000_0000_0001,
      ST_IDLE  = 11'b000_0000_0010,
      ST_CALC1 = 11'b000_0000_0100,
      ST_CALC2 = 11'b000_0000_1000,
      ST_CALC3 = 11'b000_0001_0000,
      ST_FRD   = 11'b000_0010_0000,
      ST_FWR   = 11'b000_0100_0000,
      ST_CRD   = 11'b000_1000_0000,
      ST_CWR   = 11'b001_0000_0000,
      ST_QRD   = 11'b010_0000_0000,
      ST_QANS  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CALC1;
            end
         end
         ST_CALC1: state_in = ST_CALC2;
         ST_CALC2: state_in = ST_CALC3;
         ST_CALC3: state_in = status.is_query ? ST_QRD : ST_FRD;
         ST_FRD: begin
            cmd.rd   = 1'b1;
            state_in = ST_FWR;
         end
         ST_FWR: begin
            cmd.wr   = 1'b1;
            state_in = ST_CRD;
         end
         ST_CRD: begin
            cmd.rd         = 1'b1;
            cmd.sel_coarse = 1'b1;
            state_in       = ST_CWR;
         end
         ST_CWR: begin
            cmd.wr         = 1'b1;
            cmd.sel_coarse = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_QRD: begin
            cmd.rd         = 1'b1;
            cmd.sel_coarse = status.lvl_hi;
            state_in       = ST_QANS;
         end
         ST_QANS: begin
            cmd.answer     = 1'b1;
            cmd.sel_coarse = status.lvl_hi;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire
